FILE: rtl/dpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the crane derivative block.
// No dependencies.
package dpc_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int LAT_MUL = 2;
	localparam int LAT_SIN = 13;
	localparam int LAT_DIV = WORD_W + 2;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TROLLEY_MASS = 3'd0,
		REG_UPPER_MASS   = 3'd1,
		REG_LOWER_MASS   = 3'd2,
		REG_UPPER_LENGTH = 3'd3,
		REG_LOWER_LENGTH = 3'd4,
		REG_GRAVITY      = 3'd5,
		REG_FRICTION     = 3'd6
	} cfg_reg_t;

	localparam logic [22:0] RST_TROLLEY_MASS = 23'd655360;
	localparam logic [21:0] RST_UPPER_MASS   = 22'd196608;
	localparam logic [21:0] RST_LOWER_MASS   = 22'd131072;
	localparam logic [20:0] RST_UPPER_LENGTH = 21'd131072;
	localparam logic [20:0] RST_LOWER_LENGTH = 21'd98304;
	localparam logic [20:0] RST_GRAVITY      = 21'd642908;
	localparam logic [20:0] RST_FRICTION     = 21'd65536;

	localparam logic signed [31:0] PHASE_K = 32'sd683565276;
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
	localparam logic signed [31:0] SIN_C1  = 32'sd1686629713;
	localparam logic signed [31:0] SIN_C3  = 32'sd693598672;
	localparam logic signed [31:0] SIN_C5  = 32'sd85569306;
	localparam logic signed [31:0] SIN_C7  = 32'sd5026995;
	localparam logic signed [31:0] SIN_C9  = 32'sd172272;

	localparam word_t SMAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
	localparam word_t SMIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});

	function automatic word_t sat33(input logic signed [WORD_W:0] s);
		word_t r;
		if (s[WORD_W] != s[WORD_W-1]) begin
			r = s[WORD_W] ? SMIN : SMAX;
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
		return sat33(s);
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		s = (WORD_W+1)'(a) - (WORD_W+1)'(b);
		return sat33(s);
	endfunction

	// round half away from zero, then shift right
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int sh);
		logic [63:0] m;
		logic        neg;
		neg = v[63];
		m = neg ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// product to fixed point: round half away from zero, saturate
	function automatic word_t mul_round(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] lim;
		logic        neg;
		neg = p[63];
		m = neg ? 64'(-p) : 64'(p);
		m = (m + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		lim = neg ? (64'd1 << (WORD_W - 1)) : ((64'd1 << (WORD_W - 1)) - 64'd1);
		if (m > lim) begin
			m = lim;
		end
		return neg ? WORD_W'(-m) : WORD_W'(m);
	endfunction

endpackage

FILE: rtl/dpc_if.sv
`timescale 1ns / 1ps
// Handshake channels of the crane derivative block: input items, results, config writes.
// Depends on dpc_pkg.
interface dpc_in_if;
	import dpc_pkg::*;
	logic  valid;
	logic  ready;
	word_t trolley_velocity;
	word_t upper_angle;
	word_t upper_rate;
	word_t lower_angle;
	word_t lower_rate;
	word_t drive_force;
	modport source (output valid, trolley_velocity, upper_angle, upper_rate, lower_angle,
		lower_rate, drive_force, input ready);
	modport sink (input valid, trolley_velocity, upper_angle, upper_rate, lower_angle,
		lower_rate, drive_force, output ready);
endinterface

interface dpc_out_if;
	import dpc_pkg::*;
	logic  valid;
	logic  ready;
	word_t position_rate;
	word_t trolley_accel;
	word_t upper_angle_rate;
	word_t upper_accel;
	word_t lower_angle_rate;
	word_t lower_accel;
	modport source (output valid, position_rate, trolley_accel, upper_angle_rate,
		upper_accel, lower_angle_rate, lower_accel, input ready);
	modport sink (input valid, position_rate, trolley_accel, upper_angle_rate,
		upper_accel, lower_angle_rate, lower_accel, output ready);
endinterface

interface dpc_cfg_if;
	import dpc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/dpc_delay.sv
`timescale 1ns / 1ps
// Stall-aware delay line that keeps operands aligned with the pipeline.
// Depends on dpc_pkg.
module dpc_delay #(
	parameter int WIDTH = dpc_pkg::WORD_W,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];
endmodule

FILE: rtl/dpc_mul.sv
`timescale 1ns / 1ps
// Two-stage fixed-point multiplier: raw product, then rounding and saturation.
// Depends on dpc_pkg.
module dpc_mul (
	input  logic          clk,
	input  logic          en,
	input  dpc_pkg::word_t a,
	input  dpc_pkg::word_t b,
	output dpc_pkg::word_t y
);
	import dpc_pkg::*;

	logic signed [63:0] prod_s1;
	word_t              y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a * b;
			y_s2    <= mul_round(prod_s1);
		end
	end

	assign y = y_s2;
endmodule

FILE: rtl/dpc_sine.sv
`timescale 1ns / 1ps
// Pipelined sine of a 32-bit phase: quadrant fold, Q30 odd polynomial, Q16 result.
// Depends on dpc_pkg.
module dpc_sine (
	input  logic           clk,
	input  logic           en,
	input  logic [31:0]    phase,
	output dpc_pkg::word_t sin_o
);
	import dpc_pkg::*;

	logic [1:0]         quad_s [1:12];
	logic signed [31:0] x_s    [1:11];
	logic signed [31:0] x2_s   [3:9];
	logic signed [63:0] pp2_s2, pp4_s4, pp6_s6, pp8_s8, pp10_s10, pp12_s12;
	logic signed [31:0] p5_s5, p7_s7, p9_s9, p11_s11;
	word_t              y_s13;
	logic signed [31:0] low;
	logic signed [63:0] pfin;

	assign low = {2'b00, phase[29:0]};

	always_comb begin
		pfin = rnd_shr(pp12_s12, 30);
		if (quad_s[12][1]) begin
			pfin = -pfin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[1] <= phase[31:30];
			x_s[1]    <= phase[30] ? (Q30_ONE - low) : low;
			for (int k = 2; k <= 12; k++) begin
				quad_s[k] <= quad_s[k-1];
			end
			for (int k = 2; k <= 11; k++) begin
				x_s[k] <= x_s[k-1];
			end
			pp2_s2  <= x_s[1] * x_s[1];
			x2_s[3] <= 32'(rnd_shr(pp2_s2, 30));
			for (int k = 4; k <= 9; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			pp4_s4   <= SIN_C9 * x2_s[3];
			p5_s5    <= 32'(rnd_shr(pp4_s4, 30) - 64'(SIN_C7));
			pp6_s6   <= p5_s5 * x2_s[5];
			p7_s7    <= 32'(rnd_shr(pp6_s6, 30) + 64'(SIN_C5));
			pp8_s8   <= p7_s7 * x2_s[7];
			p9_s9    <= 32'(rnd_shr(pp8_s8, 30) - 64'(SIN_C3));
			pp10_s10 <= p9_s9 * x2_s[9];
			p11_s11  <= 32'(rnd_shr(pp10_s10, 30) + 64'(SIN_C1));
			pp12_s12 <= p11_s11 * x_s[11];
			y_s13    <= WORD_W'(rnd_shr(pfin, 30 - FRAC_W));
		end
	end

	assign sin_o = y_s13;
endmodule

FILE: rtl/dpc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating fixed-point quotient.
// Depends on dpc_pkg.
module dpc_div (
	input  logic           clk,
	input  logic           en,
	input  dpc_pkg::word_t num,
	input  dpc_pkg::word_t den,
	output dpc_pkg::word_t quo
);
	import dpc_pkg::*;

	typedef struct packed {
		logic              neg;
		logic              zero;
		logic              npos;
		logic              nneg;
		logic              ovf;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] nlow;
		logic [WORD_W-1:0] q;
		logic [WORD_W-1:0] ud;
	} dstage_t;

	dstage_t           stg_s [WORD_W+1];
	dstage_t           pre;
	word_t             quo_q;
	word_t             fin;
	logic [WORD_W-1:0] un;
	logic [WORD_W-1:0] ud;
	logic [WORD_W-1:0] lim;
	logic [WORD_W-1:0] qq;

	function automatic dstage_t div_step(input dstage_t s);
		dstage_t          r;
		logic [WORD_W:0]  sh;
		logic             ge;
		r = s;
		sh = {s.rem, s.nlow[WORD_W-1]};
		ge = sh >= {1'b0, s.ud};
		r.rem  = ge ? WORD_W'(sh - {1'b0, s.ud}) : sh[WORD_W-1:0];
		r.nlow = {s.nlow[WORD_W-2:0], 1'b0};
		r.q    = {s.q[WORD_W-2:0], ge};
		return r;
	endfunction

	always_comb begin
		un = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
		ud = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
		pre.neg  = num[WORD_W-1] ^ den[WORD_W-1];
		pre.zero = (den == '0);
		pre.npos = !num[WORD_W-1] && (num != '0);
		pre.nneg = num[WORD_W-1];
		pre.ovf  = {{FRAC_W{1'b0}}, un} >= {ud, {FRAC_W{1'b0}}};
		pre.rem  = WORD_W'(un[WORD_W-1:FRAC_W]);
		pre.nlow = {un[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
		pre.q    = '0;
		pre.ud   = ud;
	end

	always_comb begin
		lim = stg_s[WORD_W].neg ? WORD_W'(SMIN) : WORD_W'(SMAX);
		qq  = (stg_s[WORD_W].ovf || stg_s[WORD_W].q > lim) ? lim : stg_s[WORD_W].q;
		if (stg_s[WORD_W].zero) begin
			fin = stg_s[WORD_W].npos ? SMAX : (stg_s[WORD_W].nneg ? SMIN : '0);
		end else begin
			fin = stg_s[WORD_W].neg ? word_t'(-qq) : word_t'(qq);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= pre;
			for (int i = 1; i <= WORD_W; i++) begin
				stg_s[i] <= div_step(stg_s[i-1]);
			end
			quo_q <= fin;
		end
	end

	assign quo = quo_q;
endmodule

FILE: rtl/double_pendulum_crane_derivative.sv
`timescale 1ns / 1ps
// Double-pendulum gantry crane derivative: six state derivatives per item, Q16.16.
// Depends on dpc_pkg, dpc_if, dpc_delay, dpc_mul, dpc_sine, dpc_div.
//
//   channel     dir  payload
//   item_in     in   trolley_velocity, upper/lower angle and rate, drive_force
//   result_out  out  position_rate, trolley_accel, angle rates, angular accels
//   cfg         in   index (register 0..6), data (up to 23 bits)
//
// One item per cycle unless the output stalls; depth is set by the sine pipelines
// and the two chained 34-stage dividers (trolley accel, then angular accels).
// Reset clears the valid chain and restores the register defaults; item_in and
// cfg stay not ready until the first cycle after reset.
// The whole pipeline holds while a result waits; cfg is ready whenever out of reset.
module double_pendulum_crane_derivative (
	input logic      clk,
	input logic      arst_n,
	dpc_in_if.sink   item_in,
	dpc_out_if.source result_out,
	dpc_cfg_if.sink  cfg
);
	import dpc_pkg::*;

	localparam int M     = LAT_MUL;
	localparam int T_IN  = 1;
	localparam int T_PH  = T_IN + 2;
	localparam int T_SIN = T_PH + LAT_SIN;
	localparam int T_T   = T_SIN + M;
	localparam int T_DX  = T_T + 2 + LAT_DIV;
	localparam int T_Q   = T_T + M + LAT_DIV;
	localparam int T_OUT = T_DX + M + 2 + LAT_DIV;

	logic [22:0] trolley_mass_q;
	logic [21:0] upper_mass_q, lower_mass_q;
	logic [20:0] upper_length_q, lower_length_q, gravity_q, friction_q;

	logic [T_OUT:1] vld_q;
	logic           adv;
	logic           run_q;

	word_t mt, m1, m2, l1, l2, g, b, m12, mtot, ng;

	word_t dx_s1, th1_s1, w1_s1, th2_s1, w2_s1, f_s1;
	logic signed [47:0] ph1_s2, ph2_s2;
	logic [31:0] p1_s3, p1c_s3, p2_s3, p2c_s3, pd_s3;

	word_t s1, c1, s2, c2, sd;
	word_t m12l1, m2l2;
	word_t f_d, bdx, acc1_s4, acc1_d;
	word_t w1_d1, w1_d2, w2_d1, w2_d2;
	word_t u1a, u1b, u1b_d, t1;
	word_t u2a, u2b, u2b_d, t2, t2_d;
	word_t va, vb, vb_d, v3, v4;
	word_t ra, rb, rb_d, r3, r3_d;
	word_t ns1, ns2, ns1_d, ns2_d;
	word_t acc2_s19, acc3_s20;
	word_t ddx, qt, qt_d, c1_d, c2_d, e1, e2;
	word_t f1_s57, f2_s57, g1_s58, g2_s58;
	word_t dd1, dd2, dx_o, w1_o, w2_o, ddx_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign cfg.ready = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trolley_mass_q <= RST_TROLLEY_MASS;
			upper_mass_q   <= RST_UPPER_MASS;
			lower_mass_q   <= RST_LOWER_MASS;
			upper_length_q <= RST_UPPER_LENGTH;
			lower_length_q <= RST_LOWER_LENGTH;
			gravity_q      <= RST_GRAVITY;
			friction_q     <= RST_FRICTION;
		end else if (cfg.valid && run_q) begin
			case (cfg_reg_t'(cfg.index))
				REG_TROLLEY_MASS: trolley_mass_q <= cfg.data[22:0];
				REG_UPPER_MASS:   upper_mass_q   <= cfg.data[21:0];
				REG_LOWER_MASS:   lower_mass_q   <= cfg.data[21:0];
				REG_UPPER_LENGTH: upper_length_q <= cfg.data[20:0];
				REG_LOWER_LENGTH: lower_length_q <= cfg.data[20:0];
				REG_GRAVITY:      gravity_q      <= cfg.data[20:0];
				REG_FRICTION:     friction_q     <= cfg.data[20:0];
				default: ;
			endcase
		end
	end

	assign mt   = WORD_W'(trolley_mass_q);
	assign m1   = WORD_W'(upper_mass_q);
	assign m2   = WORD_W'(lower_mass_q);
	assign l1   = WORD_W'(upper_length_q);
	assign l2   = WORD_W'(lower_length_q);
	assign g    = WORD_W'(gravity_q);
	assign b    = WORD_W'(friction_q);
	assign m12  = m1 + m2;
	assign mtot = mt + m1 + m2;
	assign ng   = -g;

	assign adv           = !vld_q[T_OUT] || result_out.ready;
	assign item_in.ready = adv && run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[T_OUT-1:1], item_in.valid && run_q};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= item_in.trolley_velocity;
			th1_s1 <= item_in.upper_angle;
			w1_s1  <= item_in.upper_rate;
			th2_s1 <= item_in.lower_angle;
			w2_s1  <= item_in.lower_rate;
			f_s1   <= item_in.drive_force;
			ph1_s2 <= th1_s1 * PHASE_K;
			ph2_s2 <= th2_s1 * PHASE_K;
			p1_s3  <= ph1_s2[47:16];
			p1c_s3 <= ph1_s2[47:16] + 32'h4000_0000;
			p2_s3  <= ph2_s2[47:16];
			p2c_s3 <= ph2_s2[47:16] + 32'h4000_0000;
			pd_s3  <= ph1_s2[47:16] - ph2_s2[47:16];
		end
	end

	dpc_sine u_sin1 (.clk(clk), .en(adv), .phase(p1_s3),  .sin_o(s1));
	dpc_sine u_cos1 (.clk(clk), .en(adv), .phase(p1c_s3), .sin_o(c1));
	dpc_sine u_sin2 (.clk(clk), .en(adv), .phase(p2_s3),  .sin_o(s2));
	dpc_sine u_cos2 (.clk(clk), .en(adv), .phase(p2c_s3), .sin_o(c2));
	dpc_sine u_sind (.clk(clk), .en(adv), .phase(pd_s3),  .sin_o(sd));

	dpc_mul u_m12l1 (.clk(clk), .en(adv), .a(m12), .b(l1), .y(m12l1));
	dpc_mul u_m2l2  (.clk(clk), .en(adv), .a(m2),  .b(l2), .y(m2l2));

	// friction and drive force
	dpc_mul   u_bdx (.clk(clk), .en(adv), .a(b), .b(dx_s1), .y(bdx));
	dpc_delay #(.DEPTH(M)) u_fd (.clk(clk), .en(adv), .d(f_s1), .q(f_d));
	always_ff @(posedge clk) begin
		if (adv) begin
			acc1_s4 <= sat_sub(f_d, bdx);
		end
	end
	dpc_delay #(.DEPTH(T_T - (T_IN + M + 1))) u_acc1d (.clk(clk), .en(adv), .d(acc1_s4),
		.q(acc1_d));

	dpc_delay #(.DEPTH(M)) u_w1d1 (.clk(clk), .en(adv), .d(w1_s1), .q(w1_d1));
	dpc_delay #(.DEPTH(M)) u_w1d2 (.clk(clk), .en(adv), .d(w1_d1), .q(w1_d2));
	dpc_delay #(.DEPTH(M)) u_w2d1 (.clk(clk), .en(adv), .d(w2_s1), .q(w2_d1));
	dpc_delay #(.DEPTH(M)) u_w2d2 (.clk(clk), .en(adv), .d(w2_d1), .q(w2_d2));

	// (m1+m2) l1 w1 w1 sin(a1)
	dpc_mul u_u1a (.clk(clk), .en(adv), .a(m12l1), .b(w1_d1), .y(u1a));
	dpc_mul u_u1b (.clk(clk), .en(adv), .a(u1a),   .b(w1_d2), .y(u1b));
	dpc_delay #(.DEPTH(T_SIN - (T_IN + 3*M))) u_u1bd (.clk(clk), .en(adv), .d(u1b),
		.q(u1b_d));
	dpc_mul u_t1 (.clk(clk), .en(adv), .a(u1b_d), .b(s1), .y(t1));

	// m2 l2 w2 w2 sin(a2)
	dpc_mul u_u2a (.clk(clk), .en(adv), .a(m2l2), .b(w2_d1), .y(u2a));
	dpc_mul u_u2b (.clk(clk), .en(adv), .a(u2a),  .b(w2_d2), .y(u2b));
	dpc_delay #(.DEPTH(T_SIN - (T_IN + 3*M))) u_u2bd (.clk(clk), .en(adv), .d(u2b),
		.q(u2b_d));
	dpc_mul u_t2 (.clk(clk), .en(adv), .a(u2b_d), .b(s2), .y(t2));
	dpc_delay #(.DEPTH(1)) u_t2d (.clk(clk), .en(adv), .d(t2), .q(t2_d));

	// l2 w2 w2 sin(a1-a2) m2
	dpc_mul u_va (.clk(clk), .en(adv), .a(l2), .b(w2_s1), .y(va));
	dpc_mul u_vb (.clk(clk), .en(adv), .a(va), .b(w2_d1), .y(vb));
	dpc_delay #(.DEPTH(T_SIN - (T_IN + 2*M))) u_vbd (.clk(clk), .en(adv), .d(vb), .q(vb_d));
	dpc_mul u_v3 (.clk(clk), .en(adv), .a(vb_d), .b(sd), .y(v3));
	dpc_mul u_v4 (.clk(clk), .en(adv), .a(v3),   .b(m2), .y(v4));

	// l1 w1 w1 sin(a1-a2)
	dpc_mul u_ra (.clk(clk), .en(adv), .a(l1), .b(w1_s1), .y(ra));
	dpc_mul u_rb (.clk(clk), .en(adv), .a(ra), .b(w1_d1), .y(rb));
	dpc_delay #(.DEPTH(T_SIN - (T_IN + 2*M))) u_rbd (.clk(clk), .en(adv), .d(rb), .q(rb_d));
	dpc_mul u_r3 (.clk(clk), .en(adv), .a(rb_d), .b(sd), .y(r3));

	dpc_mul u_ns1 (.clk(clk), .en(adv), .a(ng), .b(s1), .y(ns1));
	dpc_mul u_ns2 (.clk(clk), .en(adv), .a(ng), .b(s2), .y(ns2));

	always_ff @(posedge clk) begin
		if (adv) begin
			acc2_s19 <= sat_add(acc1_d, t1);
			acc3_s20 <= sat_add(acc2_s19, t2_d);
		end
	end

	dpc_div u_ddx (.clk(clk), .en(adv), .num(acc3_s20), .den(mtot), .quo(ddx));
	dpc_div u_qt  (.clk(clk), .en(adv), .num(v4),       .den(m12),  .quo(qt));

	dpc_delay #(.DEPTH(T_DX - T_SIN)) u_c1d (.clk(clk), .en(adv), .d(c1), .q(c1_d));
	dpc_delay #(.DEPTH(T_DX - T_SIN)) u_c2d (.clk(clk), .en(adv), .d(c2), .q(c2_d));
	dpc_mul u_e1 (.clk(clk), .en(adv), .a(ddx), .b(c1_d), .y(e1));
	dpc_mul u_e2 (.clk(clk), .en(adv), .a(ddx), .b(c2_d), .y(e2));

	dpc_delay #(.DEPTH(T_DX + M - T_T)) u_ns1d (.clk(clk), .en(adv), .d(ns1), .q(ns1_d));
	dpc_delay #(.DEPTH(T_DX + M - T_T)) u_ns2d (.clk(clk), .en(adv), .d(ns2), .q(ns2_d));
	dpc_delay #(.DEPTH(T_DX + M + 1 - T_Q)) u_qtd (.clk(clk), .en(adv), .d(qt), .q(qt_d));
	dpc_delay #(.DEPTH(T_DX + M + 1 - T_T)) u_r3d (.clk(clk), .en(adv), .d(r3), .q(r3_d));

	always_ff @(posedge clk) begin
		if (adv) begin
			f1_s57 <= sat_sub(ns1_d, e1);
			f2_s57 <= sat_sub(ns2_d, e2);
			g1_s58 <= sat_add(f1_s57, qt_d);
			g2_s58 <= sat_sub(f2_s57, r3_d);
		end
	end

	dpc_div u_dd1 (.clk(clk), .en(adv), .num(g1_s58), .den(l1), .quo(dd1));
	dpc_div u_dd2 (.clk(clk), .en(adv), .num(g2_s58), .den(l2), .quo(dd2));

	dpc_delay #(.DEPTH(T_OUT - T_IN)) u_dxo (.clk(clk), .en(adv), .d(dx_s1), .q(dx_o));
	dpc_delay #(.DEPTH(T_OUT - T_IN)) u_w1o (.clk(clk), .en(adv), .d(w1_s1), .q(w1_o));
	dpc_delay #(.DEPTH(T_OUT - T_IN)) u_w2o (.clk(clk), .en(adv), .d(w2_s1), .q(w2_o));
	dpc_delay #(.DEPTH(T_OUT - T_DX)) u_ddxo (.clk(clk), .en(adv), .d(ddx), .q(ddx_o));

	assign result_out.valid            = vld_q[T_OUT];
	assign result_out.position_rate    = dx_o;
	assign result_out.trolley_accel    = ddx_o;
	assign result_out.upper_angle_rate = w1_o;
	assign result_out.upper_accel      = dd1;
	assign result_out.lower_angle_rate = w2_o;
	assign result_out.lower_accel      = dd2;
endmodule
